>>> src/quat_scale_translate_to_matrix_defines.svh
`ifndef QUAT_SCALE_TRANSLATE_TO_MATRIX_DEFINES_SVH
`define QUAT_SCALE_TRANSLATE_TO_MATRIX_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define QSTM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define QSTM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/qstm_pkg.sv
`timescale 1ns / 1ps

package qstm_pkg;

    // field widths
    localparam int QW = 16;     // quaternion component, Q1.14
    localparam int SW = 16;     // axis scale, Q8.8
    localparam int TW = 32;     // translation and matrix entries

    // internal widths
    localparam int PW     = 32; // product of two components, Q.28
    localparam int TERM_W = 34; // bracketed term times two, Q.28
    localparam int FULL_W = 50; // term times scale, Q.36

    localparam int QPROD_FRAC = 28;
    localparam int FULL_FRAC  = 36;

    localparam int NUM_ENT = 9;
    localparam int NUM_AX  = 3;

    localparam int OUT_FRAC_BITS_DEF = 16;

    localparam logic signed [TERM_W-1:0] ONE_Q28 = TERM_W'(64'd1 << QPROD_FRAC);

endpackage

>>> src/quat_scale_translate_to_matrix.sv
`timescale 1ns / 1ps

// Turns one rigid transform (quaternion x,y,z,w in Q1.14, per-axis scale in Q8.8,
// translation in Q16.16) into the rotation-times-scale 3x3 block of the 4x4
// matrix plus the translation row. Row r of the rotation is multiplied by the
// scale of axis r; entries carry OUT_FRAC_BITS fraction bits, rounded to nearest
// with ties toward plus infinity and saturated to 32 bits (saturation never
// triggers at 16 fraction bits). The quaternion is used as given, with no
// normalization. Four register stages: component products, bracketed terms,
// scale multiply, round and saturate into the output register. One transform
// is taken every cycle unless back-pressure from out_ready fills the stages;
// each stage moves on when the stage after it is empty or moving, so in_ready
// follows out_ready through that valid chain in the same cycle.
module quat_scale_translate_to_matrix #(
    parameter int OUT_FRAC_BITS = qstm_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [qstm_pkg::QW-1:0]    quat_x,
    input  logic signed [qstm_pkg::QW-1:0]    quat_y,
    input  logic signed [qstm_pkg::QW-1:0]    quat_z,
    input  logic signed [qstm_pkg::QW-1:0]    quat_w,
    input  logic signed [qstm_pkg::SW-1:0]    scale_x,
    input  logic signed [qstm_pkg::SW-1:0]    scale_y,
    input  logic signed [qstm_pkg::SW-1:0]    scale_z,
    input  logic signed [qstm_pkg::TW-1:0]    trans_x,
    input  logic signed [qstm_pkg::TW-1:0]    trans_y,
    input  logic signed [qstm_pkg::TW-1:0]    trans_z,

    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [qstm_pkg::TW-1:0]    m00,
    output logic signed [qstm_pkg::TW-1:0]    m01,
    output logic signed [qstm_pkg::TW-1:0]    m02,
    output logic signed [qstm_pkg::TW-1:0]    m10,
    output logic signed [qstm_pkg::TW-1:0]    m11,
    output logic signed [qstm_pkg::TW-1:0]    m12,
    output logic signed [qstm_pkg::TW-1:0]    m20,
    output logic signed [qstm_pkg::TW-1:0]    m21,
    output logic signed [qstm_pkg::TW-1:0]    m22,
    output logic signed [qstm_pkg::TW-1:0]    row3_x,
    output logic signed [qstm_pkg::TW-1:0]    row3_y,
    output logic signed [qstm_pkg::TW-1:0]    row3_z
);

    localparam int SW     = qstm_pkg::SW;
    localparam int TW     = qstm_pkg::TW;
    localparam int PW     = qstm_pkg::PW;
    localparam int TERM_W = qstm_pkg::TERM_W;
    localparam int FULL_W = qstm_pkg::FULL_W;
    localparam int NUM_ENT = qstm_pkg::NUM_ENT;
    localparam int NUM_AX  = qstm_pkg::NUM_AX;

    localparam int SH = qstm_pkg::FULL_FRAC - OUT_FRAC_BITS;
    localparam logic signed [FULL_W-1:0] RND_HALF = FULL_W'(64'd1 << (SH - 1));
    localparam logic signed [FULL_W-1:0] OUT_MAX  = FULL_W'((64'd1 << (TW - 1)) - 64'd1);
    localparam logic signed [FULL_W-1:0] OUT_MIN  = -FULL_W'(64'd1 << (TW - 1));

    // stage handshake
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    assign en4      = !v4_reg || out_ready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;
    assign out_valid = v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= in_valid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
            if (en4)
                v4_reg <= v3_reg;
        end
    end

    // stage 1: component products, Q.28
    logic signed [PW-1:0] xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg;
    logic signed [PW-1:0] wx_reg, wy_reg, wz_reg;
    logic signed [SW-1:0] scl1_reg [NUM_AX];
    logic signed [TW-1:0] tr1_reg  [NUM_AX];

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            xx_reg <= PW'(quat_x) * PW'(quat_x);
            yy_reg <= PW'(quat_y) * PW'(quat_y);
            zz_reg <= PW'(quat_z) * PW'(quat_z);
            xy_reg <= PW'(quat_x) * PW'(quat_y);
            xz_reg <= PW'(quat_x) * PW'(quat_z);
            yz_reg <= PW'(quat_y) * PW'(quat_z);
            wx_reg <= PW'(quat_w) * PW'(quat_x);
            wy_reg <= PW'(quat_w) * PW'(quat_y);
            wz_reg <= PW'(quat_w) * PW'(quat_z);
            scl1_reg[0] <= scale_x;
            scl1_reg[1] <= scale_y;
            scl1_reg[2] <= scale_z;
            tr1_reg[0]  <= trans_x;
            tr1_reg[1]  <= trans_y;
            tr1_reg[2]  <= trans_z;
        end
    end

    // stage 2: bracketed terms, row-major order
    logic signed [TERM_W-1:0] term_next [NUM_ENT];
    logic signed [TERM_W-1:0] term_reg  [NUM_ENT];
    logic signed [SW-1:0]     scl2_reg  [NUM_AX];
    logic signed [TW-1:0]     tr2_reg   [NUM_AX];

    always_comb
    begin
        term_next[0] = qstm_pkg::ONE_Q28 - ((TERM_W'(yy_reg) + TERM_W'(zz_reg)) <<< 1);
        term_next[1] = (TERM_W'(xy_reg) + TERM_W'(wz_reg)) <<< 1;
        term_next[2] = (TERM_W'(xz_reg) - TERM_W'(wy_reg)) <<< 1;
        term_next[3] = (TERM_W'(xy_reg) - TERM_W'(wz_reg)) <<< 1;
        term_next[4] = qstm_pkg::ONE_Q28 - ((TERM_W'(xx_reg) + TERM_W'(zz_reg)) <<< 1);
        term_next[5] = (TERM_W'(yz_reg) + TERM_W'(wx_reg)) <<< 1;
        term_next[6] = (TERM_W'(xz_reg) + TERM_W'(wy_reg)) <<< 1;
        term_next[7] = (TERM_W'(yz_reg) - TERM_W'(wx_reg)) <<< 1;
        term_next[8] = qstm_pkg::ONE_Q28 - ((TERM_W'(xx_reg) + TERM_W'(yy_reg)) <<< 1);
    end

    always_ff @(posedge clk)
    begin
        if (en2 && v1_reg)
        begin
            term_reg <= term_next;
            scl2_reg <= scl1_reg;
            tr2_reg  <= tr1_reg;
        end
    end

    // stage 3: scale multiply, Q.36 (at most 2^47 in magnitude)
    logic signed [FULL_W-1:0] full_reg [NUM_ENT];
    logic signed [TW-1:0]     tr3_reg  [NUM_AX];

    // stage 4: round and saturate
    logic signed [FULL_W-1:0] rnd   [NUM_ENT];
    logic signed [FULL_W-1:0] shr   [NUM_ENT];
    logic signed [TW-1:0]     m_next [NUM_ENT];
    logic signed [TW-1:0]     m_reg  [NUM_ENT];
    logic signed [TW-1:0]     tr4_reg [NUM_AX];

    for (genvar i = 0; i < NUM_ENT; i++)
    begin : g_ent
        always_ff @(posedge clk)
        begin
            if (en3 && v2_reg)
                full_reg[i] <= FULL_W'(term_reg[i]) * FULL_W'(scl2_reg[i / NUM_AX]);
        end

        always_comb
        begin
            rnd[i] = full_reg[i] + RND_HALF;
            shr[i] = rnd[i] >>> SH;
            priority if (shr[i] > OUT_MAX)
                m_next[i] = OUT_MAX[TW-1:0];
            else if (shr[i] < OUT_MIN)
                m_next[i] = OUT_MIN[TW-1:0];
            else
                m_next[i] = shr[i][TW-1:0];
        end

        always_ff @(posedge clk)
        begin
            if (en4 && v3_reg)
                m_reg[i] <= m_next[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3 && v2_reg)
            tr3_reg <= tr2_reg;
        if (en4 && v3_reg)
            tr4_reg <= tr3_reg;
    end

    assign m00    = m_reg[0];
    assign m01    = m_reg[1];
    assign m02    = m_reg[2];
    assign m10    = m_reg[3];
    assign m11    = m_reg[4];
    assign m12    = m_reg[5];
    assign m20    = m_reg[6];
    assign m21    = m_reg[7];
    assign m22    = m_reg[8];
    assign row3_x = tr4_reg[0];
    assign row3_y = tr4_reg[1];
    assign row3_z = tr4_reg[2];

endmodule

>>> src/qstm_checker.sv
`timescale 1ns / 1ps
`include "quat_scale_translate_to_matrix_defines.svh"

module qstm_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic signed [qstm_pkg::TW-1:0]    m00,
    input  logic signed [qstm_pkg::TW-1:0]    m11,
    input  logic signed [qstm_pkg::TW-1:0]    m22,
    input  logic signed [qstm_pkg::TW-1:0]    row3_x
);

    // a stalled result beat stays up
    `QSTM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid, "out beat dropped while stalled")

    // and keeps its payload
    `QSTM_ASSERT_NEXT(a_out_stable, out_valid && !out_ready,
        $stable(m00) && $stable(m11) && $stable(m22) && $stable(row3_x),
        "out payload changed while stalled")

    // input side never stalls while the output register is free or draining
    `QSTM_ASSERT_SAME(a_in_free, !out_valid || out_ready,
        in_ready, "input stalled with output free")

    // a result that appears after an empty output traces back to an accepted input beat
    `QSTM_ASSERT_SAME(a_latency, $rose(out_valid),
        $past(in_valid && in_ready, 4), "out beat without input beat four cycles earlier")

endmodule

bind quat_scale_translate_to_matrix qstm_checker u_qstm_checker (.*);

>>> test/quat_scale_translate_to_matrix_tb.sv
`timescale 1ns / 1ps

module quat_scale_translate_to_matrix_tb;

    localparam int QW          = qstm_pkg::QW;
    localparam int SW          = qstm_pkg::SW;
    localparam int TW          = qstm_pkg::TW;
    localparam int QPROD_FRAC  = qstm_pkg::QPROD_FRAC;
    localparam int OUT_FRAC    = qstm_pkg::OUT_FRAC_BITS_DEF;
    localparam int RND_SHIFT   = qstm_pkg::FULL_FRAC - OUT_FRAC;
    localparam int NUM_RANDOM  = 1200;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 20;
    localparam int LONG_HOLD   = 300;

    typedef struct packed {
        logic signed [QW-1:0] qx;
        logic signed [QW-1:0] qy;
        logic signed [QW-1:0] qz;
        logic signed [QW-1:0] qw;
        logic signed [SW-1:0] sx;
        logic signed [SW-1:0] sy;
        logic signed [SW-1:0] sz;
        logic signed [TW-1:0] tx;
        logic signed [TW-1:0] ty;
        logic signed [TW-1:0] tz;
        bit                   wait_drain;
    } xform_t;

    // ent[0..8] = m00..m22, ent[9..11] = row3 x,y,z
    typedef struct packed {
        logic [11:0][TW-1:0] ent;
    } mat_t;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic signed [QW-1:0] quat_x, quat_y, quat_z, quat_w;
    logic signed [SW-1:0] scale_x, scale_y, scale_z;
    logic signed [TW-1:0] trans_x, trans_y, trans_z;
    logic out_valid;
    logic out_ready;
    logic signed [TW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic signed [TW-1:0] row3_x, row3_y, row3_z;

    xform_t xform_q[$];
    mat_t   expected_mats[$];
    xform_t cur_xform;

    bit in_fire = 1'b0;
    int accepted_cnt = 0;
    int results_cnt = 0;
    int mismatch_cnt = 0;
    int item_total = 0;
    int cycle_cnt = 0;

    int  send_gap = 0;
    bit  send_calm = 1'b0;
    int  rx_stall = 0;
    bit  rx_calm = 1'b0;
    bit  long_hold_done = 1'b0;

    quat_scale_translate_to_matrix #(
        .OUT_FRAC_BITS(OUT_FRAC)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .quat_x(quat_x),
        .quat_y(quat_y),
        .quat_z(quat_z),
        .quat_w(quat_w),
        .scale_x(scale_x),
        .scale_y(scale_y),
        .scale_z(scale_z),
        .trans_x(trans_x),
        .trans_y(trans_y),
        .trans_z(trans_z),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .m00(m00),
        .m01(m01),
        .m02(m02),
        .m10(m10),
        .m11(m11),
        .m12(m12),
        .m20(m20),
        .m21(m21),
        .m22(m22),
        .row3_x(row3_x),
        .row3_y(row3_y),
        .row3_z(row3_z)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Q.36 down to OUT_FRAC fraction bits, ties toward +inf, clamp to 32 bits
    function automatic logic [TW-1:0] q36_to_entry(longint v);
        longint r;
        if (RND_SHIFT > 0)
            r = (v + (longint'(1) <<< (RND_SHIFT - 1))) >>> RND_SHIFT;
        else
            r = v;
        if (r > longint'(32'sh7fffffff))
            r = longint'(32'sh7fffffff);
        if (r < -longint'(64'h80000000))
            r = -longint'(64'h80000000);
        return r[TW-1:0];
    endfunction

    function automatic mat_t rotate_scale(xform_t t);
        longint x, y, z, w, sx, sy, sz, one;
        longint xx, yy, zz, xy, xz, yz, wx, wy, wz;
        mat_t m;
        one = longint'(1) <<< QPROD_FRAC;
        x = $signed(t.qx);
        y = $signed(t.qy);
        z = $signed(t.qz);
        w = $signed(t.qw);
        sx = $signed(t.sx);
        sy = $signed(t.sy);
        sz = $signed(t.sz);
        xx = x * x;
        yy = y * y;
        zz = z * z;
        xy = x * y;
        xz = x * z;
        yz = y * z;
        wx = w * x;
        wy = w * y;
        wz = w * z;
        m.ent[0] = q36_to_entry((one - 2 * (yy + zz)) * sx);
        m.ent[1] = q36_to_entry((2 * (xy + wz)) * sx);
        m.ent[2] = q36_to_entry((2 * (xz - wy)) * sx);
        m.ent[3] = q36_to_entry((2 * (xy - wz)) * sy);
        m.ent[4] = q36_to_entry((one - 2 * (xx + zz)) * sy);
        m.ent[5] = q36_to_entry((2 * (yz + wx)) * sy);
        m.ent[6] = q36_to_entry((2 * (xz + wy)) * sz);
        m.ent[7] = q36_to_entry((2 * (yz - wx)) * sz);
        m.ent[8] = q36_to_entry((one - 2 * (xx + yy)) * sz);
        m.ent[9] = t.tx;
        m.ent[10] = t.ty;
        m.ent[11] = t.tz;
        return m;
    endfunction

    function automatic string entry_name(int i);
        case (i)
            0: return "m00";
            1: return "m01";
            2: return "m02";
            3: return "m10";
            4: return "m11";
            5: return "m12";
            6: return "m20";
            7: return "m21";
            8: return "m22";
            9: return "row3_x";
            10: return "row3_y";
            default: return "row3_z";
        endcase
    endfunction

    task automatic add_xform(int qx, int qy, int qz, int qw, int sx, int sy, int sz,
                             logic [31:0] tx, logic [31:0] ty, logic [31:0] tz, bit drain);
        xform_t t;
        t.qx = qx[QW-1:0];
        t.qy = qy[QW-1:0];
        t.qz = qz[QW-1:0];
        t.qw = qw[QW-1:0];
        t.sx = sx[SW-1:0];
        t.sy = sy[SW-1:0];
        t.sz = sz[SW-1:0];
        t.tx = tx;
        t.ty = ty;
        t.tz = tz;
        t.wait_drain = drain;
        xform_q.push_back(t);
        item_total++;
    endtask

    function automatic int rand_quat_comp();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return 16384;
        if (r < 8)
            return -16384;
        if (r < 13)
            return 0;
        if (r < 23)
            return int'($urandom_range(0, 64)) - 32;
        return int'($urandom_range(0, 32768)) - 16384;
    endfunction

    function automatic int rand_scale();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return 32767;
        if (r < 6)
            return -32768;
        if (r < 12)
            return ($urandom_range(0, 1) != 0) ? 256 : -256;
        if (r < 22)
            return int'($urandom_range(0, 1024)) - 512;
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic logic [31:0] rand_trans();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return 32'h7fffffff;
        if (r < 6)
            return 32'h80000000;
        if (r < 8)
            return 32'h0;
        return $urandom();
    endfunction

    // sender: offers the next transform once the last one was taken
    always @(negedge clk)
    begin : drive_proc
        int r;
        xform_t t;
        if (rst_n && (!in_valid || in_fire))
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (xform_q.size() > 0 &&
                     !(xform_q[0].wait_drain && expected_mats.size() != 0))
            begin
                t = xform_q.pop_front();
                cur_xform <= t;
                quat_x <= t.qx;
                quat_y <= t.qy;
                quat_z <= t.qz;
                quat_w <= t.qw;
                scale_x <= t.sx;
                scale_y <= t.sy;
                scale_z <= t.sz;
                trans_x <= t.tx;
                trans_y <= t.ty;
                trans_z <= t.tz;
                in_valid <= 1'b1;
                r = $urandom_range(0, 999);
                if (r < 20)
                    send_calm = !send_calm;
                if (send_calm || r < 550)
                    send_gap <= 0;
                else if (r < 850)
                    send_gap <= $urandom_range(1, 3);
                else if (r < 970)
                    send_gap <= $urandom_range(4, 15);
                else
                    send_gap <= $urandom_range(20, 80);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus one long hold to back up the pipeline
    always @(negedge clk)
    begin : recv_proc
        int r;
        if (rst_n)
        begin
            if (!long_hold_done && results_cnt >= 300)
            begin
                long_hold_done = 1'b1;
                rx_stall = LONG_HOLD;
            end
            if (rx_stall == 0)
            begin
                r = $urandom_range(0, 999);
                if (r < 10)
                    rx_calm = !rx_calm;
                else if (!rx_calm && r < 200)
                    rx_stall = $urandom_range(1, 3);
                else if (!rx_calm && r < 225)
                    rx_stall = $urandom_range(8, 40);
            end
            if (rx_stall > 0)
            begin
                rx_stall = rx_stall - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : watch_proc
        mat_t got;
        mat_t want;
        if (rst_n)
        begin
            in_fire <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                expected_mats.push_back(rotate_scale(cur_xform));
                accepted_cnt <= accepted_cnt + 1;
            end
            if (out_valid && out_ready)
            begin
                results_cnt <= results_cnt + 1;
                got.ent = {row3_z, row3_y, row3_x, m22, m21, m20, m12, m11, m10,
                           m02, m01, m00};
                if (expected_mats.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, m00 %h", $time, m00);
                    mismatch_cnt++;
                end
                else
                begin
                    want = expected_mats.pop_front();
                    for (int i = 0; i < 12; i++)
                    begin
                        if (got.ent[i] !== want.ent[i])
                        begin
                            $display("%0t: %s expected %h actual %h", $time,
                                     entry_name(i), want.ent[i], got.ent[i]);
                            mismatch_cnt++;
                        end
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results still expected", $time,
                     expected_mats.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        quat_x = '0;
        quat_y = '0;
        quat_z = '0;
        quat_w = '0;
        scale_x = '0;
        scale_y = '0;
        scale_z = '0;
        trans_x = '0;
        trans_y = '0;
        trans_z = '0;
        cur_xform = '0;

        // identity, extremes, axis flips, unnormalized and zero quaternions
        add_xform(0, 0, 0, 16384, 256, 256, 256, 32'h0, 32'h0, 32'h0, 1'b0);
        add_xform(16384, 16384, 16384, 16384, 32767, 32767, 32767,
                  32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0);
        add_xform(-16384, -16384, -16384, -16384, -32768, -32768, -32768,
                  32'h80000000, 32'h80000000, 32'h80000000, 1'b0);
        add_xform(0, 0, 0, 0, 256, 256, 256, 32'hffffffff, 32'h1, 32'h0, 1'b0);
        add_xform(16384, 0, 0, 0, 256, -256, 512, 32'h00010000, 32'hffff0000, 32'h0, 1'b0);
        add_xform(0, 16384, 0, 0, -512, 256, -256, 32'h0, 32'h00010000, 32'h0, 1'b0);
        add_xform(0, 0, 16384, 0, 32767, -32768, 1, 32'h0, 32'h0, 32'h00010000, 1'b0);
        add_xform(16384, -16384, 16384, -16384, -1, 1, 0,
                  32'h12345678, 32'h9abcdef0, 32'h0f0f0f0f, 1'b0);
        add_xform(-16384, 16384, -16384, 16384, 32767, -32768, 32767,
                  32'h80000000, 32'h7fffffff, 32'hffffffff, 1'b0);
        // rounding: exact halves go up, so +0.5 -> 1 and -0.5 -> 0
        add_xform(512, 256, 0, 0, 2, 2, 2, 32'h0, 32'h0, 32'h0, 1'b0);
        add_xform(512, 256, 0, 0, -2, -2, -2, 32'h0, 32'h0, 32'h0, 1'b0);
        add_xform(512, 256, 0, 0, 3, -3, 1, 32'h0, 32'h0, 32'h0, 1'b0);
        add_xform(256, 512, 512, 256, -1, -2, 2, 32'h0, 32'h0, 32'h0, 1'b0);
        add_xform(1, 1, 1, 1, 1, 1, 1, 32'h1, 32'h1, 32'h1, 1'b0);
        add_xform(-1, -1, -1, -1, -32768, -32768, -32768,
                  32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b0);
        add_xform(11585, 0, 0, 11585, 256, 256, 256, 32'haaaaaaaa, 32'h55555555, 32'h0, 1'b0);
        add_xform(10922, -10923, 10922, -10923, 16'h5555, -21846, 21845,
                  32'h55555555, 32'haaaaaaaa, 32'hdeadbeef, 1'b0);
        add_xform(8192, 8192, 8192, 8192, 128, -128, 32767, 32'h7fff0000, 32'h8000ffff,
                  32'h00000001, 1'b0);

        // random transforms, with two points where the sender drains first
        for (int n = 0; n < NUM_RANDOM; n++)
            add_xform(rand_quat_comp(), rand_quat_comp(), rand_quat_comp(), rand_quat_comp(),
                      rand_scale(), rand_scale(), rand_scale(),
                      rand_trans(), rand_trans(), rand_trans(), n == 0 || n == 700);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (accepted_cnt != item_total || expected_mats.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_cnt == 0 && expected_mats.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
